// ===== rtl/core/magofb_pkg.sv =====
package magofb_pkg;

	localparam int FB_BLOCKS = 4;
	localparam int KEY_WORDS = 8;
	localparam int ROUNDS = 32;
	localparam int RND_W = $clog2(ROUNDS);
	localparam int KIDX_W = $clog2(KEY_WORDS);
	localparam int CFG_IDX_W = 4;
	localparam logic [RND_W-1:0] LAST_LOOP_RND = RND_W'(ROUNDS - 2);
	localparam logic [RND_W-1:0] FINAL_RND = RND_W'(ROUNDS - 1);
	localparam logic [RND_W-1:0] REVERSE_RND = RND_W'(24);

	localparam logic [3:0] SBOX [KEY_WORDS][16] = '{
		'{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
		  4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
		'{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
		  4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
		'{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
		  4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
		'{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
		  4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
		'{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
		  4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
		'{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
		  4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
		'{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
		  4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
		'{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
		  4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
	};

	typedef enum logic [1:0] {
		STEP_IDLE,
		STEP_ROUNDS,
		STEP_FINAL
	} step_t;

	typedef enum logic [1:0] {
		COND_NEVER,
		COND_NO_DATA,
		COND_ROUND_LOOP,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		logic  accept_en;
		logic  round_en;
		logic  finish_en;
		cond_t cond;
		step_t target;
	} ucw_t;

	typedef struct packed {
		logic             accept;
		logic             round_en;
		logic             finish;
		logic [RND_W-1:0] rnd;
	} dp_ctl_t;

	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

	function automatic ucw_t ucode(input step_t step);
		ucw_t w;
		w = '{accept_en: 1'b0, round_en: 1'b0, finish_en: 1'b0,
		      cond: COND_NEVER, target: STEP_IDLE};
		case (step)
			STEP_IDLE: begin
				w.accept_en = 1'b1;
				w.cond = COND_NO_DATA;
				w.target = STEP_IDLE;
			end
			STEP_ROUNDS: begin
				w.round_en = 1'b1;
				w.cond = COND_ROUND_LOOP;
				w.target = STEP_ROUNDS;
			end
			STEP_FINAL: begin
				w.finish_en = 1'b1;
				w.cond = COND_OUT_BUSY;
				w.target = STEP_FINAL;
			end
			default: begin
				w.cond = COND_NO_DATA;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	function automatic logic [31:0] round_fn(input logic [31:0] half, input logic [31:0] rk);
		logic [31:0] t;
		logic [31:0] s;
		t = half + rk;
		for (int i = 0; i < 8; i++) begin
			s[4*i +: 4] = SBOX[i][t[4*i +: 4]];
		end
		return {s[20:0], s[31:21]};
	endfunction

	function automatic logic [63:0] pad_block(input logic [63:0] blk, input logic [3:0] count);
		logic [63:0] r;
		if (count >= 4'd8) begin
			r = blk;
		end else begin
			for (int i = 0; i < 8; i++) begin
				r[63 - 8*i -: 8] = (4'(i) < count) ? blk[63 - 8*i -: 8] : 8'h00;
			end
			r[7:0] = 8'(4'd8 - count);
		end
		return r;
	endfunction

	function automatic logic [KIDX_W-1:0] key_index(input logic [RND_W-1:0] rnd);
		return (rnd < REVERSE_RND) ? rnd[KIDX_W-1:0] : ~rnd[KIDX_W-1:0];
	endfunction

endpackage

// ===== rtl/core/magofb_cipher_top.sv =====
// Magma OFB keystream block with a four-block feedback register.
// A data item is encrypted in 32 rounds, one per cycle, the last of which waits in the final
// step while a stalled result is held; no new item is taken until its result is registered.
// An IV item is absorbed in its acceptance cycle, so IV items stream one per cycle.
// The round loop is set by a single shared round unit driven by the step sequencer.
// Reset clears the key words, sequencer and output valid; the feedback blocks are not cleared.
module magma_ofb_cipher_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             action,
	input  logic [63:0]                      data_block,
	input  logic [3:0]                       byte_count,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [63:0]                      out_block,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [magofb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data
);
	import magofb_pkg::*;

	dp_ctl_t  ctl;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	magofb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.stat     (stat),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	magofb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.action     (action),
		.data_block (data_block),
		.byte_count (byte_count),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_block  (out_block)
	);

endmodule

// ===== rtl/core/magofb_seq.sv =====
module magofb_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                action,
	input  magofb_pkg::dp_stat_t stat,
	output logic                in_stall,
	output magofb_pkg::dp_ctl_t ctl
);
	import magofb_pkg::*;

	step_t            step_q;
	step_t            step_d;
	logic [RND_W-1:0] rnd_q;
	ucw_t             ucw;
	logic             take;
	logic             accept;

	assign ucw = ucode(step_q);
	assign accept = ucw.accept_en && in_valid;

	always_comb begin
		case (ucw.cond)
			COND_NEVER:      take = 1'b0;
			COND_NO_DATA:    take = !(in_valid && action);
			COND_ROUND_LOOP: take = (rnd_q != LAST_LOOP_RND);
			COND_OUT_BUSY:   take = stat.out_busy;
			default:         take = 1'b0;
		endcase
	end

	always_comb begin
		if (take) begin
			step_d = ucw.target;
		end else begin
			case (step_q)
				STEP_IDLE:   step_d = STEP_ROUNDS;
				STEP_ROUNDS: step_d = STEP_FINAL;
				STEP_FINAL:  step_d = STEP_IDLE;
				default:     step_d = STEP_IDLE;
			endcase
		end
	end

	always_comb begin
		in_stall = !ucw.accept_en;
		ctl.accept = accept;
		ctl.round_en = ucw.round_en;
		ctl.finish = ucw.finish_en && !stat.out_busy;
		ctl.rnd = rnd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
			rnd_q <= '0;
		end else begin
			step_q <= step_d;
			if (accept) begin
				rnd_q <= '0;
			end else if (ucw.round_en) begin
				rnd_q <= rnd_q + 1'b1;
			end
		end
	end

	a_final_round: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == STEP_FINAL |-> rnd_q == FINAL_RND)
		else $error("final step reached with wrong round count");

	a_loop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == STEP_ROUNDS |-> rnd_q <= LAST_LOOP_RND)
		else $error("round loop overran");

	a_data_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && action) |=> (step_q == STEP_ROUNDS && rnd_q == '0))
		else $error("data item did not start the round loop");

	a_iv_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !action) |=> step_q == STEP_IDLE)
		else $error("IV item left the idle step");

endmodule

// ===== rtl/core/magofb_dp.sv =====
module magofb_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  magofb_pkg::dp_ctl_t           ctl,
	output magofb_pkg::dp_stat_t          stat,
	input  logic                          action,
	input  logic [63:0]                   data_block,
	input  logic [3:0]                    byte_count,
	input  logic                          cfg_valid,
	input  logic [magofb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [63:0]                   out_block
);
	import magofb_pkg::*;

	logic [31:0] key_q [KEY_WORDS];
	logic [63:0] fb_q [FB_BLOCKS];
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [63:0] pad_q;
	logic        out_valid_q;
	logic [63:0] out_block_q;
	logic [31:0] f_out;
	logic [31:0] t_half;
	logic [63:0] ks;
	logic        push;
	logic [63:0] push_val;

	assign f_out = round_fn(lo_q, key_q[key_index(ctl.rnd)]);
	assign t_half = hi_q ^ f_out;
	assign ks = {t_half, lo_q};
	assign push = ctl.finish || (ctl.accept && !action);
	assign push_val = ctl.finish ? ks : data_block;

	assign stat.out_busy = out_valid_q && out_stall;
	assign out_valid = out_valid_q;
	assign out_block = out_block_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index < CFG_IDX_W'(KEY_WORDS)) begin
				key_q[cfg_index[KIDX_W-1:0]] <= cfg_data;
			end
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < FB_BLOCKS - 1; i++) begin
				fb_q[i] <= fb_q[i + 1];
			end
			fb_q[FB_BLOCKS - 1] <= push_val;
		end
		if (ctl.accept && action) begin
			hi_q <= fb_q[0][63:32];
			lo_q <= fb_q[0][31:0];
			pad_q <= pad_block(data_block, byte_count);
		end else if (ctl.round_en) begin
			hi_q <= lo_q;
			lo_q <= t_half;
		end
		if (ctl.finish) begin
			out_block_q <= pad_q ^ ks;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> !(out_valid_q && out_stall))
		else $error("result written over a stalled item");

	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.accept && (ctl.round_en || ctl.finish)))
		else $error("accept overlaps an item in progress");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_block_q)))
		else $error("stalled result changed");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import magofb_pkg::*;

	localparam logic ACT_IV = 1'b0;
	localparam logic ACT_DATA = 1'b1;
	localparam int N_PHASES = 6;
	localparam int RAND_PER_PHASE = 265;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 50;

	localparam logic [3:0] SUBST [8][16] = '{
		'{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
		  4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
		'{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
		  4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
		'{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
		  4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
		'{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
		  4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
		'{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
		  4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
		'{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
		  4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
		'{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
		  4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
		'{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
		  4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
	};

	typedef struct packed {
		logic        act;
		logic [63:0] blk;
		logic [3:0]  cnt;
	} ofb_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 action = ACT_IV;
	logic [63:0]          data_block = '0;
	logic [3:0]           byte_count = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [63:0]          out_block;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	ofb_item_t   pending_q[$];
	logic [63:0] cipher_q[$];
	logic [31:0] key_model [KEY_WORDS];
	logic [63:0] fb_model [FB_BLOCKS];
	ofb_item_t   cur_item;
	int          n_sent = 0;
	int          n_taken = 0;
	int          fails = 0;
	int          cycles = 0;
	int          in_gap = 0;
	int          out_hold = 0;
	bit          calm_in = 1'b0;
	bit          calm_out = 1'b0;

	magma_ofb_cipher_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.data_block (data_block),
		.byte_count (byte_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_block  (out_block),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	function automatic logic [31:0] gost_f(input logic [31:0] half, input logic [31:0] rk);
		logic [31:0] t;
		logic [31:0] s;
		t = half + rk;
		for (int i = 0; i < 8; i++) begin
			s[4*i +: 4] = SUBST[i][t[4*i +: 4]];
		end
		return (s << 11) | (s >> 21);
	endfunction

	function automatic logic [63:0] magma_block(input logic [63:0] blk);
		logic [31:0] hi;
		logic [31:0] lo;
		logic [31:0] t;
		int ki;
		hi = blk[63:32];
		lo = blk[31:0];
		for (int r = 0; r < ROUNDS; r++) begin
			ki = (r < 24) ? r % KEY_WORDS : ROUNDS - 1 - r;
			t = hi ^ gost_f(lo, key_model[ki]);
			if (r < ROUNDS - 1) begin
				hi = lo;
				lo = t;
			end else begin
				hi = t;
			end
		end
		return {hi, lo};
	endfunction

	function automatic logic [63:0] padded(input logic [63:0] blk, input logic [3:0] cnt);
		int c;
		logic [63:0] keep;
		c = cnt;
		if (c >= 8) begin
			return blk;
		end
		keep = (c == 0) ? 64'd0 : ~64'd0 << (8 * (8 - c));
		return (blk & keep) | 64'(8 - c);
	endfunction

	task automatic ofb_predict(input ofb_item_t it);
		logic [63:0] fresh;
		if (it.act == ACT_DATA) begin
			fresh = magma_block(fb_model[0]);
			cipher_q.push_back(padded(it.blk, it.cnt) ^ fresh);
		end else begin
			fresh = it.blk;
		end
		for (int i = 0; i < FB_BLOCKS - 1; i++) begin
			fb_model[i] = fb_model[i + 1];
		end
		fb_model[FB_BLOCKS - 1] = fresh;
	endtask

	task automatic queue_item(input logic act, input logic [63:0] blk, input logic [3:0] cnt);
		ofb_item_t it;
		it.act = act;
		it.blk = blk;
		it.cnt = cnt;
		pending_q.push_back(it);
		n_sent++;
	endtask

	task automatic queue_random();
		logic act;
		logic [63:0] blk;
		logic [3:0] cnt;
		act = ($urandom_range(0, 9) < 3) ? ACT_IV : ACT_DATA;
		case ($urandom_range(0, 15))
			0: blk = '0;
			1: blk = '1;
			default: blk = {$urandom, $urandom};
		endcase
		cnt = $urandom_range(0, 1) ? 4'd8 : 4'($urandom_range(0, 15));
		queue_item(act, blk, cnt);
	endtask

	// The extra write goes to an unmapped index and must leave the key alone.
	task automatic load_keys(input logic [31:0] kw [KEY_WORDS]);
		cfg_valid <= 1'b1;
		for (int i = 0; i <= KEY_WORDS; i++) begin
			if (i < KEY_WORDS) begin
				cfg_index <= CFG_IDX_W'(i);
				cfg_data <= kw[i];
			end else begin
				cfg_index <= CFG_IDX_W'($urandom_range(KEY_WORDS, 2**CFG_IDX_W - 1));
				cfg_data <= $urandom;
			end
			do @(posedge clk); while (!cfg_ready);
			if (i < KEY_WORDS) begin
				key_model[i] = kw[i];
			end
		end
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_IV;
			data_block <= '0;
			byte_count <= '0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				ofb_predict(cur_item);
				n_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap != 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					cur_item = pending_q.pop_front();
					action <= cur_item.act;
					data_block <= cur_item.blk;
					byte_count <= cur_item.cnt;
					in_valid <= 1'b1;
					in_gap = draw_wait(calm_in);
					if ($urandom_range(0, 63) == 0) begin
						calm_in = !calm_in;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (cipher_q.size() == 0) begin
					fails++;
					if (fails <= MAX_REPORTS) begin
						$display("%0t: out_block expected none actual %h", $time, out_block);
					end
				end else if (cipher_q[0] !== out_block) begin
					fails++;
					if (fails <= MAX_REPORTS) begin
						$display("%0t: out_block expected %h actual %h",
							$time, cipher_q[0], out_block);
					end
					void'(cipher_q.pop_front());
				end else begin
					void'(cipher_q.pop_front());
				end
				out_hold = draw_wait(calm_out);
				if ($urandom_range(0, 63) == 0) begin
					calm_out = !calm_out;
				end
			end else if (out_valid && out_hold != 0) begin
				out_hold--;
			end
			out_stall <= (out_hold != 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [31:0] kw [KEY_WORDS];
		for (int i = 0; i < FB_BLOCKS; i++) begin
			fb_model[i] = '0;
		end
		for (int i = 0; i < KEY_WORDS; i++) begin
			key_model[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < N_PHASES; ph++) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				kw[i] = (ph == 0) ? 32'h0 : (ph == 1) ? 32'hffffffff : $urandom;
			end
			load_keys(kw);
			if (ph == 0) begin
				// Fill the whole feedback register before the first data item.
				queue_item(ACT_IV, 64'h0, 4'd8);
				queue_item(ACT_IV, '1, 4'd8);
				queue_item(ACT_IV, 64'h0123456789abcdef, 4'd8);
				queue_item(ACT_IV, 64'hfedcba9876543210, 4'd8);
				for (int c = 0; c < 16; c++) begin
					queue_item(ACT_DATA, c[0] ? '1 : 64'h0123456789abcdef, 4'(c));
				end
				queue_item(ACT_IV, 64'h8000000000000001, 4'd15);
				queue_item(ACT_DATA, 64'h0, 4'd8);
			end
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				queue_random();
			end
			while (n_taken != n_sent || cipher_q.size() != 0) begin
				@(posedge clk);
			end
			repeat (TAIL_CYCLES) @(posedge clk);
		end
		if (fails == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
